// ===== sv/clock_sync_event_tracker_top_assert.svh =====
// Assertion macros for the clock sync event tracker
`ifndef CLOCK_SYNC_EVENT_TRACKER_TOP_ASSERT_SVH
`define CLOCK_SYNC_EVENT_TRACKER_TOP_ASSERT_SVH
`define CSET_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define CSET_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== sv/cset_pkg.sv =====
// Shared types for the clock sync event tracker
`default_nettype none
package cset_pkg;
  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_READ   = 1'b1;
  localparam logic [1:0] REG_WATCH = 2'd0;
  localparam logic [1:0] REG_COMP  = 2'd1;
  localparam logic [1:0] REG_PTHR  = 2'd2;
  localparam logic [1:0] REG_STHR  = 2'd3;
  localparam int CFG_W = 31;

  typedef struct packed {
    logic        func;
    logic [3:0]  base_index;
    logic [63:0] primary_offset;
    logic        locked_to_primary;
    logic [63:0] source_id;
    logic        link_capable;
    logic [63:0] system_offset;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  watch_mask;
    logic [2:0]  composite_mask;
    logic [30:0] primary_threshold;
    logic [30:0] system_threshold;
  } cfg_t;

  typedef struct packed {
    logic pri_in;
    logic sys_in;
  } cls_t;

  function automatic logic in_window(input logic [63:0] x, input logic [30:0] t);
    logic [63:0] s;
    s = x + {33'd0, t};
    return s <= {32'd0, t, 1'b0};
  endfunction
endpackage
`default_nettype wire

// ===== sv/clock_sync_event_tracker_top.sv =====
// Top level of the clock sync event tracker
`default_nettype none
`include "clock_sync_event_tracker_top_assert.svh"
// Each command returns one result beat on done, which the receiver must take
// in that cycle. The front takes a command when start is high and busy is
// low, classifies both offsets and queues it, holding busy after each take
// and while the queue is full; the back reads one table entry in a fetch
// phase and writes it back in a write phase, so neither side takes commands
// back to back. With the queue empty, a command passes the front's push
// register, queue and both back phases. Updates return an all-zero result.
module clock_sync_event_tracker_top #(
  parameter int NUM_BASES  = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        func,
  input  wire logic [3:0]  base_index,
  input  wire logic [63:0] primary_offset,
  input  wire logic        locked_to_primary,
  input  wire logic [63:0] source_id,
  input  wire logic        link_capable,
  input  wire logic [63:0] system_offset,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [cset_pkg::CFG_W-1:0] cfg_data,
  output logic             done,
  output logic             found,
  output logic             changed,
  output logic [4:0]       flags,
  output logic [63:0]      offset_out,
  output logic [63:0]      source_out,
  output logic [15:0]      range_count,
  output logic [15:0]      lock_count,
  output logic [15:0]      source_count,
  output logic [15:0]      capable_count,
  output logic [15:0]      composite_count,
  output logic             system_in_range,
  output logic [15:0]      system_count
);
  import cset_pkg::*;
  cfg_t cfg;
  always_ff @(posedge clk) begin
    if (rst) cfg <= '0;
    else if (cfg_we) begin
      case (cfg_index)
        REG_WATCH: cfg.watch_mask        <= cfg_data[3:0];
        REG_COMP:  cfg.composite_mask    <= cfg_data[2:0];
        REG_PTHR:  cfg.primary_threshold <= cfg_data;
        REG_STHR:  cfg.system_threshold  <= cfg_data;
        default: ;
      endcase
    end
  end

  cmd_t cmd_in, f_cmd, h_cmd;
  cls_t f_cls, h_cls;
  logic accept, f_push, q_full, q_avail, pop;
  assign cmd_in = '{func, base_index, primary_offset, locked_to_primary,
                    source_id, link_capable, system_offset};
  assign busy = start && !accept;

  cset_front u_front (.clk, .rst, .start, .cmd_in, .cfg, .q_full, .accept,
    .q_push(f_push), .q_cmd(f_cmd), .q_cls(f_cls));
  cset_queue u_queue (.clk, .rst, .push(f_push), .push_cmd(f_cmd), .push_cls(f_cls),
    .pop, .full(q_full), .avail(q_avail), .head_cmd(h_cmd), .head_cls(h_cls));
  cset_back #(.NUM_BASES(NUM_BASES), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst, .avail(q_avail), .cmd(h_cmd), .cls(h_cls), .cfg, .pop, .done,
    .found, .changed, .flags, .offset_out, .source_out, .range_count,
    .lock_count, .source_count, .capable_count, .composite_count,
    .system_in_range, .system_count);

  `CSET_ASSERT_IMPL(a_no_push_full, f_push, !q_full || pop)
  `CSET_ASSERT_NEXT(a_pop_done, pop, done)
  `CSET_ASSERT_IMPL(a_found_read, done && !found, !changed && flags == 5'd0)
endmodule
`default_nettype wire

// ===== sv/cset_front.sv =====
// Front end: takes commands, classifies offsets, feeds the queue
`default_nettype none
module cset_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire cset_pkg::cmd_t cmd_in,
  input  wire cset_pkg::cfg_t cfg,
  input  wire logic           q_full,
  output logic                accept,
  output logic                q_push,
  output cset_pkg::cmd_t      q_cmd,
  output cset_pkg::cls_t      q_cls
);
  import cset_pkg::*;
  logic hold;
  assign accept = start && !hold;
  always_ff @(posedge clk) begin
    if (rst) begin
      hold   <= 1'b0;
      q_push <= 1'b0;
    end else begin
      // one beat in flight at the front; release once the queue took it
      q_push <= accept;
      hold   <= accept || (hold && q_full);
    end
    if (accept) begin
      q_cmd        <= cmd_in;
      q_cls.pri_in <= in_window(cmd_in.primary_offset, cfg.primary_threshold);
      q_cls.sys_in <= in_window(cmd_in.system_offset, cfg.system_threshold);
    end
  end
endmodule
`default_nettype wire

// ===== sv/cset_queue.sv =====
// Two-entry queue between front and back
`default_nettype none
module cset_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire cset_pkg::cmd_t push_cmd,
  input  wire cset_pkg::cls_t push_cls,
  input  wire logic           pop,
  output logic                full,
  output logic                avail,
  output cset_pkg::cmd_t      head_cmd,
  output cset_pkg::cls_t      head_cls
);
  import cset_pkg::*;
  cmd_t cmd_q [2];
  cls_t cls_q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  assign full  = cnt == 2'd2;
  assign avail = cnt != 2'd0;
  assign head_cmd = cmd_q[rp];
  assign head_cls = cls_q[rp];
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      cmd_q[wp] <= push_cmd;
      cls_q[wp] <= push_cls;
    end
  end
endmodule
`default_nettype wire

// ===== sv/cset_back.sv =====
// Back end: entry table read-modify-write and result register
`default_nettype none
module cset_back #(
  parameter int NUM_BASES  = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           avail,
  input  wire cset_pkg::cmd_t cmd,
  input  wire cset_pkg::cls_t cls,
  input  wire cset_pkg::cfg_t cfg,
  output logic                pop,
  output logic                done,
  output logic                found,
  output logic                changed,
  output logic [4:0]          flags,
  output logic [63:0]         offset_out,
  output logic [63:0]         source_out,
  output logic [15:0]         range_count,
  output logic [15:0]         lock_count,
  output logic [15:0]         source_count,
  output logic [15:0]         capable_count,
  output logic [15:0]         composite_count,
  output logic                system_in_range,
  output logic [15:0]         system_count
);
  import cset_pkg::*;
  localparam int IW = (NUM_BASES > 1) ? $clog2(NUM_BASES) : 1;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  typedef logic [COUNT_BITS-1:0] cnt_t;

  logic [NUM_BASES-1:0] valid;
  logic [63:0] off_m [NUM_BASES];
  logic [63:0] src_m [NUM_BASES];
  logic [63:0] sof_m [NUM_BASES];
  logic [4:0]  flg_m [NUM_BASES];
  logic        sin_m [NUM_BASES];
  logic        chg_m [NUM_BASES];
  cnt_t        cnt_m [NUM_BASES][6];

  logic in_tab;
  logic [IW-1:0] idx;
  assign in_tab = {5'd0, cmd.base_index} < 9'(NUM_BASES);
  assign idx = IW'(cmd.base_index);

  // each item has a fetch phase, then a write phase
  logic ph;
  logic [63:0] e_off, e_src, e_sof;
  logic [4:0] e_flg;
  logic e_sin, e_chg, e_val;
  cnt_t e_cnt [6];

  always_ff @(posedge clk) begin
    if (avail && !ph) begin
      e_val <= in_tab && valid[idx];
      e_off <= off_m[idx]; e_src <= src_m[idx]; e_sof <= sof_m[idx];
      e_flg <= flg_m[idx]; e_sin <= sin_m[idx]; e_chg <= chg_m[idx];
      for (int k = 0; k < 6; k++) e_cnt[k] <= cnt_m[idx][k];
    end
  end

  function automatic cnt_t bump(input cnt_t c);
    return (c == CMAX) ? c : c + cnt_t'(1);
  endfunction

  logic [63:0] n_off, n_src, n_sof;
  logic [4:0] n_flg;
  logic n_sin, n_chg, comp;
  cnt_t n_cnt [6];
  always_comb begin
    n_off = e_val ? e_off : '0; n_src = e_val ? e_src : '0;
    n_sof = e_val ? e_sof : '0; n_flg = e_val ? e_flg : '0;
    n_sin = e_val && e_sin;     n_chg = e_val && e_chg;
    for (int k = 0; k < 6; k++) n_cnt[k] = e_val ? e_cnt[k] : '0;
    comp = 1'b1;
    if (cfg.watch_mask[0] && cmd.primary_offset != n_off) begin
      n_off = cmd.primary_offset;
      if (cls.pri_in != n_flg[0]) begin
        n_flg[0] = cls.pri_in; n_cnt[0] = bump(n_cnt[0]); n_chg = 1'b1;
      end
    end
    if (cfg.watch_mask[1] && cmd.locked_to_primary != n_flg[1]) begin
      n_flg[1] = cmd.locked_to_primary; n_cnt[1] = bump(n_cnt[1]); n_chg = 1'b1;
    end
    if (cfg.watch_mask[2] && cmd.source_id != n_src) begin
      n_src = cmd.source_id; n_flg[2] = 1'b1; n_cnt[2] = bump(n_cnt[2]); n_chg = 1'b1;
    end
    if (cfg.watch_mask[3] && cmd.link_capable != n_flg[3]) begin
      n_flg[3] = cmd.link_capable; n_cnt[3] = bump(n_cnt[3]); n_chg = 1'b1;
    end
    if (cfg.composite_mask[0]) comp = comp && n_flg[0];
    if (cfg.composite_mask[1]) comp = comp && n_flg[1];
    if (cfg.composite_mask[2]) comp = comp && n_flg[3];
    if (cfg.composite_mask != 3'd0 && comp != n_flg[4]) begin
      n_flg[4] = comp; n_cnt[4] = bump(n_cnt[4]); n_chg = 1'b1;
    end
    if (cmd.system_offset != n_sof) begin
      n_sof = cmd.system_offset;
      if (cls.sys_in != n_sin) begin
        n_sin = cls.sys_in; n_cnt[5] = bump(n_cnt[5]); n_chg = 1'b1;
      end
    end
  end

  logic is_rd;
  assign is_rd = cmd.func == FUNC_READ;
  assign pop = avail && ph;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= 1'b0; done <= 1'b0; valid <= '0;
    end else begin
      done <= pop;
      if (avail) ph <= ~ph;
      if (pop && !is_rd && in_tab) valid[idx] <= 1'b1;
    end
    if (pop) begin
      if (!is_rd && in_tab) begin
        off_m[idx] <= n_off; src_m[idx] <= n_src; sof_m[idx] <= n_sof;
        flg_m[idx] <= n_flg; sin_m[idx] <= n_sin; chg_m[idx] <= n_chg;
        for (int k = 0; k < 6; k++) cnt_m[idx][k] <= n_cnt[k];
      end else if (is_rd && e_val) begin
        flg_m[idx][2] <= 1'b0; chg_m[idx] <= 1'b0;
        for (int k = 0; k < 6; k++) cnt_m[idx][k] <= '0;
      end
      found   <= is_rd && e_val;
      changed <= is_rd && e_val && e_chg;
      flags   <= (is_rd && e_val) ? e_flg : '0;
      offset_out <= (is_rd && e_val) ? e_off : '0;
      source_out <= (is_rd && e_val) ? e_src : '0;
      system_in_range <= is_rd && e_val && e_sin;
      range_count     <= (is_rd && e_val) ? 16'(32'(e_cnt[0])) : '0;
      lock_count      <= (is_rd && e_val) ? 16'(32'(e_cnt[1])) : '0;
      source_count    <= (is_rd && e_val) ? 16'(32'(e_cnt[2])) : '0;
      capable_count   <= (is_rd && e_val) ? 16'(32'(e_cnt[3])) : '0;
      composite_count <= (is_rd && e_val) ? 16'(32'(e_cnt[4])) : '0;
      system_count    <= (is_rd && e_val) ? 16'(32'(e_cnt[5])) : '0;
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for the clock sync event tracker: random and directed commands, scoreboard check
module tb;
  import cset_pkg::*;

  typedef struct packed {
    logic        found;
    logic        changed;
    logic [4:0]  flags;
    logic [63:0] offset_out;
    logic [63:0] source_out;
    logic [15:0] range_count;
    logic [15:0] lock_count;
    logic [15:0] source_count;
    logic [15:0] capable_count;
    logic [15:0] composite_count;
    logic        system_in_range;
    logic [15:0] system_count;
  } status_t;

  localparam int NBASE = 16;
  localparam int unsigned CNT_TOP = 65535;
  localparam int K_RANGE = 0, K_LOCK = 1, K_SRC = 2, K_CAP = 3, K_COMP = 4, K_SYS = 5;
  localparam logic [4:0] F_RANGE = 5'd1, F_LOCK = 5'd2, F_SRC = 5'd4, F_CAP = 5'd8,
                         F_COMP = 5'd16;

  class tracker_scoreboard;
    logic [3:0]  watch;
    logic [2:0]  comp;
    logic [30:0] pthr;
    logic [30:0] sthr;
    bit          valid [NBASE];
    logic [63:0] off [NBASE];
    logic [63:0] src [NBASE];
    logic [63:0] soff [NBASE];
    logic [4:0]  fl [NBASE];
    int unsigned cnt [NBASE][6];
    bit          sys_in [NBASE];
    bit          chg [NBASE];
    status_t     expected_status [$];
    int          errors;

    function new();
      watch = '0; comp = '0; pthr = '0; sthr = '0; errors = 0;
      foreach (valid[i]) valid[i] = 0;
    endfunction

    function bit in_range(logic [63:0] x, logic [30:0] t);
      longint v, th;
      v = x;
      th = longint'(t);
      return v >= -th && v <= th;
    endfunction

    function int unsigned bump(int unsigned c);
      return c < CNT_TOP ? c + 1 : c;
    endfunction

    function void set_cfg(logic [1:0] idx, logic [30:0] d);
      case (idx)
        REG_WATCH: watch = d[3:0];
        REG_COMP:  comp = d[2:0];
        REG_PTHR:  pthr = d;
        REG_STHR:  sthr = d;
        default: ;
      endcase
    endfunction

    function void note_cmd(cmd_t c);
      status_t s;
      int i;
      bit r, cv;
      s = '0;
      i = int'(c.base_index);
      if (c.func == FUNC_UPDATE) begin
        if (!valid[i]) begin
          valid[i] = 1; off[i] = '0; src[i] = '0; soff[i] = '0; fl[i] = '0;
          sys_in[i] = 0; chg[i] = 0;
          for (int k = 0; k < 6; k++) cnt[i][k] = 0;
        end
        if (watch[0] && c.primary_offset != off[i]) begin
          r = in_range(c.primary_offset, pthr);
          off[i] = c.primary_offset;
          if (r != fl[i][0]) begin
            fl[i][0] = r; cnt[i][K_RANGE] = bump(cnt[i][K_RANGE]); chg[i] = 1;
          end
        end
        if (watch[1] && c.locked_to_primary != fl[i][1]) begin
          fl[i][1] = c.locked_to_primary; cnt[i][K_LOCK] = bump(cnt[i][K_LOCK]); chg[i] = 1;
        end
        if (watch[2] && c.source_id != src[i]) begin
          src[i] = c.source_id; fl[i] = fl[i] | F_SRC;
          cnt[i][K_SRC] = bump(cnt[i][K_SRC]); chg[i] = 1;
        end
        if (watch[3] && c.link_capable != fl[i][3]) begin
          fl[i][3] = c.link_capable; cnt[i][K_CAP] = bump(cnt[i][K_CAP]); chg[i] = 1;
        end
        if (comp != 0) begin
          cv = (!comp[0] || fl[i][0]) && (!comp[1] || fl[i][1]) && (!comp[2] || fl[i][3]);
          if (cv != fl[i][4]) begin
            fl[i][4] = cv; cnt[i][K_COMP] = bump(cnt[i][K_COMP]); chg[i] = 1;
          end
        end
        if (c.system_offset != soff[i]) begin
          r = in_range(c.system_offset, sthr);
          soff[i] = c.system_offset;
          if (r != sys_in[i]) begin
            sys_in[i] = r; cnt[i][K_SYS] = bump(cnt[i][K_SYS]); chg[i] = 1;
          end
        end
      end else if (valid[i]) begin
        s.found = 1; s.changed = chg[i]; s.flags = fl[i];
        s.offset_out = off[i]; s.source_out = src[i];
        s.range_count = cnt[i][K_RANGE][15:0];
        s.lock_count = cnt[i][K_LOCK][15:0];
        s.source_count = cnt[i][K_SRC][15:0];
        s.capable_count = cnt[i][K_CAP][15:0];
        s.composite_count = cnt[i][K_COMP][15:0];
        s.system_in_range = sys_in[i];
        s.system_count = cnt[i][K_SYS][15:0];
        for (int k = 0; k < 6; k++) cnt[i][k] = 0;
        fl[i] = fl[i] & ~F_SRC;
        chg[i] = 0;
      end
      expected_status.push_back(s);
    endfunction

    function void mism(string name, logic [63:0] e, logic [63:0] a);
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, e, a);
      errors++;
    endfunction

    function void check_result(status_t a);
      status_t e;
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected result beat %0h", $time, a);
        errors++;
        return;
      end
      e = expected_status.pop_front();
      if (a.found !== e.found) mism("found", e.found, a.found);
      if (a.changed !== e.changed) mism("changed", e.changed, a.changed);
      if (a.flags !== e.flags) mism("flags", e.flags, a.flags);
      if (a.offset_out !== e.offset_out) mism("offset_out", e.offset_out, a.offset_out);
      if (a.source_out !== e.source_out) mism("source_out", e.source_out, a.source_out);
      if (a.range_count !== e.range_count) mism("range_count", e.range_count, a.range_count);
      if (a.lock_count !== e.lock_count) mism("lock_count", e.lock_count, a.lock_count);
      if (a.source_count !== e.source_count)
        mism("source_count", e.source_count, a.source_count);
      if (a.capable_count !== e.capable_count)
        mism("capable_count", e.capable_count, a.capable_count);
      if (a.composite_count !== e.composite_count)
        mism("composite_count", e.composite_count, a.composite_count);
      if (a.system_in_range !== e.system_in_range)
        mism("system_in_range", e.system_in_range, a.system_in_range);
      if (a.system_count !== e.system_count)
        mism("system_count", e.system_count, a.system_count);
    endfunction
  endclass

  logic        clk, rst, start, busy, func, locked_to_primary, link_capable;
  logic [3:0]  base_index;
  logic [63:0] primary_offset, source_id, system_offset;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic        done;
  status_t     res;

  tracker_scoreboard sb;
  bit quiet;

  clock_sync_event_tracker_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .base_index(base_index), .primary_offset(primary_offset),
    .locked_to_primary(locked_to_primary), .source_id(source_id),
    .link_capable(link_capable), .system_offset(system_offset),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .found(res.found), .changed(res.changed), .flags(res.flags),
    .offset_out(res.offset_out), .source_out(res.source_out),
    .range_count(res.range_count), .lock_count(res.lock_count),
    .source_count(res.source_count), .capable_count(res.capable_count),
    .composite_count(res.composite_count), .system_in_range(res.system_in_range),
    .system_count(res.system_count)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk)
    if (!rst && done) sb.check_result(res);

  task automatic issue(input cmd_t c);
    @(negedge clk);
    func <= c.func; base_index <= c.base_index; primary_offset <= c.primary_offset;
    locked_to_primary <= c.locked_to_primary; source_id <= c.source_id;
    link_capable <= c.link_capable; system_offset <= c.system_offset;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_cmd(c);
    if (!quiet && $urandom_range(99) < 20) begin
      @(negedge clk);
      start <= 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  // idle the command side and let every outstanding beat come back
  task automatic drain();
    @(negedge clk);
    start <= 0;
    while (sb.expected_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [30:0] d);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
    @(negedge clk);
    cfg_we <= 0;
    sb.set_cfg(idx, d);
  endtask

  task automatic load_cfg(input logic [3:0] w, input logic [2:0] cm,
                          input logic [30:0] pt, input logic [30:0] st);
    drain();
    write_cfg(REG_WATCH, {27'd0, w});
    write_cfg(REG_COMP, {28'd0, cm});
    write_cfg(REG_PTHR, pt);
    write_cfg(REG_STHR, st);
  endtask

  function automatic logic [63:0] pick_offset(logic [30:0] t);
    longint th;
    th = longint'(t);
    case ($urandom_range(9))
      0: return 64'd0;
      1: return th;
      2: return -th;
      3: return th + 1;
      4: return -th - 1;
      5: return 64'h8000_0000_0000_0000;
      6: return 64'h7fff_ffff_ffff_ffff;
      7: return {$urandom, $urandom};
      default: return longint'($urandom_range(200)) - 100;
    endcase
  endfunction

  function automatic cmd_t rand_cmd(int max_idx);
    cmd_t c;
    c.func = ($urandom_range(99) < 30) ? FUNC_READ : FUNC_UPDATE;
    c.base_index = 4'($urandom_range(max_idx));
    c.primary_offset = pick_offset(sb.pthr);
    c.locked_to_primary = 1'($urandom_range(1));
    c.source_id = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(3));
    c.link_capable = 1'($urandom_range(1));
    c.system_offset = pick_offset(sb.sthr);
    return c;
  endfunction

  function automatic cmd_t mk(logic f, logic [3:0] i, logic [63:0] po, logic lk,
                              logic [63:0] sid, logic cp, logic [63:0] so);
    cmd_t c;
    c.func = f; c.base_index = i; c.primary_offset = po; c.locked_to_primary = lk;
    c.source_id = sid; c.link_capable = cp; c.system_offset = so;
    return c;
  endfunction

  initial begin
    cmd_t c;
    sb = new();
    quiet = 0;
    rst = 1; start = 0; func = 0; base_index = '0; primary_offset = '0;
    locked_to_primary = 0; source_id = '0; link_capable = 0; system_offset = '0;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // defaults: nothing watched, update creates a bare entry
    issue(mk(FUNC_READ, 4'd15, '0, 0, '0, 0, '0));
    issue(mk(FUNC_UPDATE, 4'd15, 64'd7, 1, 64'hffff_ffff_ffff_ffff, 1, 64'd3));
    issue(mk(FUNC_READ, 4'd15, '0, 0, '0, 0, '0));

    load_cfg(4'hf, 3'h7, 31'd100, 31'd50);
    issue(mk(FUNC_UPDATE, 4'd0, 64'd100, 1, 64'h0123_4567_89ab_cdef, 1, 64'd50));
    issue(mk(FUNC_READ, 4'd0, '0, 0, '0, 0, '0));
    issue(mk(FUNC_UPDATE, 4'd0, -64'sd101, 0, 64'h0123_4567_89ab_cdef, 0, -64'sd51));
    issue(mk(FUNC_UPDATE, 4'd0, -64'sd100, 1, 64'hffff_ffff_ffff_ffff, 1, -64'sd50));
    issue(mk(FUNC_UPDATE, 4'd0, -64'sd100, 1, 64'd0, 1, -64'sd50));
    issue(mk(FUNC_READ, 4'd0, '0, 0, '0, 0, '0));
    issue(mk(FUNC_UPDATE, 4'd0, 64'h8000_0000_0000_0000, 0, 64'd1, 0,
             64'h7fff_ffff_ffff_ffff));
    issue(mk(FUNC_UPDATE, 4'd0, 64'h7fff_ffff_ffff_ffff, 1, 64'd1, 1,
             64'h8000_0000_0000_0000));
    issue(mk(FUNC_READ, 4'd0, '0, 0, '0, 0, '0));
    issue(mk(FUNC_READ, 4'd0, '0, 0, '0, 0, '0));
    issue(mk(FUNC_READ, 4'd9, '0, 0, '0, 0, '0));

    load_cfg(4'h0, 3'h0, 31'h7fff_ffff, 31'h7fff_ffff);
    issue(mk(FUNC_UPDATE, 4'd0, 64'd5, 0, 64'd9, 0, 64'h7fff_ffff));
    issue(mk(FUNC_UPDATE, 4'd0, 64'd5, 0, 64'd9, 0, 64'h8000_0000));
    issue(mk(FUNC_READ, 4'd0, '0, 0, '0, 0, '0));

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_cfg(4'hf, 3'h7, 31'h7fff_ffff, 31'h7fff_ffff);
        1: load_cfg(4'h0, 3'h0, 31'd0, 31'd0);
        2: load_cfg(4'hf, 3'h7, 31'd20, 31'd30);
        default: load_cfg(4'($urandom_range(15)), 3'($urandom_range(7)),
                          ($urandom_range(1) ? 31'($urandom) : 31'($urandom_range(100))),
                          ($urandom_range(1) ? 31'($urandom) : 31'($urandom_range(100))));
      endcase
      quiet = (ph == 2);
      for (int n = 0; n < 210; n++) begin
        c = rand_cmd((ph == 4) ? 15 : 3);
        issue(c);
      end
    end
    quiet = 0;

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_status.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (sb.expected_status.size() != 0)
        $display("%0t: %0d results never arrived", $time, sb.expected_status.size());
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/cset_pkg.sv
sv/cset_front.sv
sv/cset_queue.sv
sv/cset_back.sv
sv/clock_sync_event_tracker_top.sv
tb/sv/tb.sv
